// ----- design/minstd_random_in_range_core_assert.svh -----
// Assertion macros for the minstd random-in-range core.
// Included by the top level; needs nothing else.
`ifndef MINSTD_RANDOM_IN_RANGE_CORE_ASSERT_SVH
`define MINSTD_RANDOM_IN_RANGE_CORE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define MRR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrr assertion failed");

// Check that cons holds in the cycle after ante.
`define MRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrr assertion failed");

`endif

// ----- design/mrr_pkg.sv -----
// Shared widths, constants and unit status types for the minstd core.
// No dependencies.
package mrr_pkg;

  localparam int StateW   = 31;               // generator state and bounds
  localparam int SpanW    = StateW + 1;       // span reaches 2^31
  localparam int MulW     = 16;               // width of the Lehmer multiplier
  localparam int StepCntW = $clog2(StateW);   // one step per state bit

  localparam logic [MulW-1:0]     LehmerMul = 16'd48271;
  localparam logic [StepCntW-1:0] LastStep  = StepCntW'(StateW - 1);

  typedef struct packed {
    logic              done;
    logic [StateW-1:0] lo;   // product bits 30..0
    logic [MulW-1:0]   hi;   // product bits 46..31
  } mul_res_t;

  typedef struct packed {
    logic              done;
    logic [StateW-1:0] rem;
  } div_res_t;

endpackage

// ----- design/mrr_req_if.sv -----
// Request channel: two bounds per beat.
// Depends on mrr_pkg.
interface mrr_req_if import mrr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [StateW-1:0] bound_a;
  logic signed [StateW-1:0] bound_b;

  modport source (output valid, output bound_a, output bound_b, input ready);
  modport sink   (input valid, input bound_a, input bound_b, output ready);
endinterface

// ----- design/mrr_rsp_if.sv -----
// Result channel: one random value per beat.
// Depends on mrr_pkg.
interface mrr_rsp_if import mrr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [StateW-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

// ----- design/mrr_mul.sv -----
// Serial-parallel multiplier: state times 48271, one state bit per cycle.
// Depends on mrr_pkg.
module mrr_mul import mrr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [StateW-1:0] operand_i,
  output mul_res_t          res_o
);

  logic                busy_q, done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [StateW-1:0]   opnd_q, prod_q;
  logic [MulW-1:0]     acc_q;
  logic [MulW:0]       sum;

  // add the partial product for the current bit, retire the low bit
  assign sum = {1'b0, acc_q} + (opnd_q[0] ? {1'b0, LehmerMul} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opnd_q <= operand_i;
      acc_q  <= '0;
      prod_q <= '0;
    end else if (busy_q) begin
      opnd_q <= {1'b0, opnd_q[StateW-1:1]};
      acc_q  <= sum[MulW:1];
      prod_q <= {sum[0], prod_q[StateW-1:1]};
    end
  end

  assign res_o.done = done_q;
  assign res_o.lo   = prod_q;
  assign res_o.hi   = acc_q;

endmodule

// ----- design/mrr_div.sv -----
// Restoring remainder unit: state mod span, one quotient bit per cycle.
// Depends on mrr_pkg.
module mrr_div import mrr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [StateW-1:0] dividend_i,
  input  logic [SpanW-1:0]  divisor_i,
  output div_res_t          res_o
);

  logic                busy_q, done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [StateW-1:0]   dvd_q;
  logic [SpanW-1:0]    rem_q, dvs_q;
  logic [SpanW-1:0]    trial;

  // remainder stays below the span, so its top bit is free for the shift
  assign trial = {rem_q[SpanW-2:0], dvd_q[StateW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[StateW-2:0], 1'b0};
      rem_q <= (trial >= dvs_q) ? (trial - dvs_q) : trial;
    end
  end

  assign res_o.done = done_q;
  assign res_o.rem  = rem_q[StateW-1:0];

endmodule

// ----- design/minstd_random_in_range_core.sv -----
// Random integer in an inclusive range from a MINSTD Lehmer generator
// (multiplier 48271, modulus 2^31-1). Each request beat carries two signed
// 31-bit bounds in either order; the result beat carries a value between them,
// inclusive. A request with unequal bounds passes through these steps from
// accept to result valid: order the bounds and form the span, the serial
// multiplier (one state bit per cycle), the two Mersenne folds, the restoring
// remainder unit (one quotient bit per cycle) and the load of the output
// register once it is free. Equal bounds go straight to the output register
// without advancing the generator. One request is in flight at a time; the
// next one is taken as soon as the previous result sits in the output
// register, even if that result has not been taken yet. After reset the
// generator state is zero and is loaded from seed_value (APB byte address 0,
// reset 1; a seed of zero loads 1) on the next request.
// Depends on mrr_pkg, mrr_req_if, mrr_rsp_if, mrr_mul, mrr_div and the
// assertion macro header.
`include "minstd_random_in_range_core_assert.svh"

module minstd_random_in_range_core import mrr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrr_req_if.sink     req,
  mrr_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StPrep = 6'b000010,
    StMul  = 6'b000100,
    StFold = 6'b001000,
    StDiv  = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  localparam logic [1:0] SeedAddr = 2'd0;

  state_e state_q, state_d;

  logic [StateW-1:0]        seed_q;
  logic [StateW-1:0]        gen_state_q;
  logic [StateW-1:0]        seed_load;
  logic signed [StateW-1:0] a_q, b_q, lo_q, lo_sel, hi_sel;
  logic [SpanW-1:0]         span_q, span_d;
  logic [SpanW-1:0]         fold1_q;
  logic [StateW-1:0]        fold2;
  logic [StateW-1:0]        res_q;
  logic                     out_valid_q;
  logic [StateW-1:0]        out_data_q;
  logic                     in_beat, out_beat, out_free, cfg_wr;
  mul_res_t                 mul_res;
  div_res_t                 div_res;

  // ---------------------------------------------------------------------
  // Configuration port: one register at byte address 0, no wait states.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {1'b0, seed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= StateW'(1);
    end else if (cfg_wr && (paddr == SeedAddr)) begin
      seed_q <= pwdata[StateW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  assign req.ready        = (state_q == StIdle);
  assign in_beat          = req.valid && req.ready;
  assign out_beat         = rsp.valid && rsp.ready;
  assign out_free         = !out_valid_q || rsp.ready;
  assign rsp.valid        = out_valid_q;
  assign rsp.random_value = out_data_q;

  // never let a zero seed stick the generator at zero
  assign seed_load = (seed_q != '0) ? seed_q : StateW'(1);

  // order the bounds; span = hi - lo + 1 needs the extra bit for 2^31
  assign lo_sel = (a_q < b_q) ? a_q : b_q;
  assign hi_sel = (a_q < b_q) ? b_q : a_q;
  assign span_d = {hi_sel[StateW-1], hi_sel} - {lo_sel[StateW-1], lo_sel} + SpanW'(1);

  // second fold: the carry out of the first one wraps back into bit 0
  assign fold2 = fold1_q[StateW-1:0] + StateW'(fold1_q[SpanW-1]);

  mrr_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == StPrep),
    .operand_i (gen_state_q),
    .res_o     (mul_res)
  );

  mrr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == StFold),
    .dividend_i (fold2),
    .divisor_i  (span_q),
    .res_o      (div_res)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          state_d = (req.bound_a == req.bound_b) ? StOut : StPrep;
        end
      end
      StPrep: state_d = StMul;
      StMul: begin
        if (mul_res.done) begin
          state_d = StFold;
        end
      end
      StFold: state_d = StDiv;
      StDiv: begin
        if (div_res.done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      gen_state_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // load the seed on first use, advance only after the folds
      if (in_beat && (gen_state_q == '0)) begin
        gen_state_q <= seed_load;
      end else if (state_q == StFold) begin
        gen_state_q <= fold2;
      end
      // hold the result until taken; a new one lands only when free
      if (state_q == StOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_beat) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      a_q   <= req.bound_a;
      b_q   <= req.bound_b;
      res_q <= req.bound_a;   // equal bounds return the bound itself
    end
    if (state_q == StPrep) begin
      lo_q   <= lo_sel;
      span_q <= span_d;
    end
    if (state_q == StMul && mul_res.done) begin
      fold1_q <= SpanW'(mul_res.lo) + SpanW'(mul_res.hi);
    end
    if (state_q == StDiv && div_res.done) begin
      // the remainder is below the span, so the sum stays in range
      res_q <= lo_q + div_res.rem;
    end
    if (state_q == StOut && out_free) begin
      out_data_q <= res_q;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `MRR_ASSERT_SAME(a_mul_done_in_mul, clk_i, rst_ni, mul_res.done, state_q == StMul)
  `MRR_ASSERT_SAME(a_div_done_in_div, clk_i, rst_ni, div_res.done, state_q == StDiv)
  `MRR_ASSERT_NEXT(a_state_seeded, clk_i, rst_ni, in_beat, gen_state_q != '0)
  `MRR_ASSERT_NEXT(a_out_loaded, clk_i, rst_ni, state_q == StOut && out_free, out_valid_q)

endmodule

// ----- sim/minstd_random_in_range_core_tb.sv -----
// Self-checking testbench for minstd_random_in_range_core: directed and random
// bound pairs, APB seed writes with read-back, results checked beat by beat.
// Depends on mrr_pkg, mrr_req_if, mrr_rsp_if and the core itself.
module minstd_random_in_range_core_tb;
  import mrr_pkg::*;

  // Bounds span the whole 31-bit signed range.
  localparam logic signed [StateW-1:0] MinBound = 31'h4000_0000;
  localparam logic signed [StateW-1:0] MaxBound = 31'h3fff_ffff;
  localparam logic [63:0] StateMask = 64'h7fff_ffff;
  localparam logic [1:0]  SeedAddr  = 2'd0;

  localparam int RandomPerPhase = 550;
  localparam int DrainCycles    = 100;   // a little over one unequal-bounds draw
  localparam int PressureAt     = 1000;  // result count that starts the long hold-off
  localparam int HoldCycles     = 300;
  localparam int TimeoutCycles  = 1_000_000;

  // Per random phase: sender idle and receiver stall odds (percent), seed written.
  localparam int          SendIdle  [3] = '{11, 51, 0};
  localparam int          RecvStall [3] = '{51, 11, 0};
  localparam logic [31:0] PhaseSeed [3] = '{32'h7fff_ffff, 32'h0000_0001, 32'h7fff_fffe};

  // One directed row: two bounds, and a fixed result where it is obvious.
  typedef struct packed {
    logic signed [StateW-1:0] a;
    logic signed [StateW-1:0] b;
    logic                     fixed;
    logic signed [StateW-1:0] want;
  } probe_t;

  localparam int NumProbes = 19;
  localparam probe_t Probes [NumProbes] = '{
    // a               b                fixed  want
    '{31'sd0,          31'sd0,          1'b1,  31'sd0},  // first draw: zero seed loads 1
    '{MinBound,        MinBound,        1'b1,  MinBound},
    '{MaxBound,        MaxBound,        1'b1,  MaxBound},
    '{-31'sd1,         -31'sd1,         1'b1,  -31'sd1},
    '{31'sd0,          31'sd1,          1'b0,  31'sd0},
    '{31'sd1,          31'sd0,          1'b0,  31'sd0},  // reversed bounds
    '{MinBound,        MaxBound,        1'b0,  31'sd0},  // full span
    '{MaxBound,        MinBound,        1'b0,  31'sd0},
    '{-31'sd1,         31'sd0,          1'b0,  31'sd0},
    '{MinBound,        31'h4000_0001,   1'b0,  31'sd0},
    '{31'h3fff_fffe,   MaxBound,        1'b0,  31'sd0},
    '{31'sd5,          -31'sd5,         1'b0,  31'sd0},
    '{31'h2aaa_aaaa,   31'h5555_5555,   1'b0,  31'sd0},
    '{31'h5555_5555,   31'h2aaa_aaaa,   1'b0,  31'sd0},
    '{-31'sd7,         -31'sd7000000,   1'b0,  31'sd0},
    '{31'sd100,        31'sd100000,     1'b0,  31'sd0},
    '{31'sd0,          MaxBound,        1'b0,  31'sd0},
    '{MinBound,        31'sd0,          1'b0,  31'sd0},
    '{31'h2aaa_aaaa,   31'h2aaa_aaaa,   1'b1,  31'h2aaa_aaaa}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mrr_req_if req_ch ();
  mrr_rsp_if rsp_ch ();

  minstd_random_in_range_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Generator state and seed register as the block should hold them.
  logic [StateW-1:0] lehmer_state = '0;
  logic [StateW-1:0] seed_copy    = StateW'(1);

  logic signed [StateW-1:0] pending_draws [$];
  int mismatches     = 0;
  int results_seen   = 0;
  int send_idle_pct  = SendIdle[0];
  int recv_stall_pct = RecvStall[0];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Advance the Lehmer state for one request and return the value in range.
  // Load the seed first if the state is still zero; equal bounds leave the
  // state where it is.
  function automatic logic signed [StateW-1:0] draw_in_range(
      input logic signed [StateW-1:0] a, input logic signed [StateW-1:0] b);
    logic signed [StateW-1:0] lo;
    logic signed [StateW-1:0] hi;
    logic [63:0] prod;
    logic [31:0] folded;
    logic [31:0] span;
    logic [31:0] offset;
    if (lehmer_state == '0) lehmer_state = (seed_copy != '0) ? seed_copy : StateW'(1);
    if (a == b) return a;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    // Multiply, then fold the product twice at bit 31.
    prod   = 64'(lehmer_state) * 64'(LehmerMul);
    folded = 32'((prod & StateMask) + (prod >> StateW));
    prod   = 64'(folded);
    folded = 32'((prod & StateMask) + (prod >> StateW));
    lehmer_state = folded[StateW-1:0];
    // Span reaches 2^31 for the full range, so keep it in 32 bits.
    span   = 32'(longint'(hi) - longint'(lo) + 64'sd1);
    offset = {1'b0, lehmer_state} % span;
    return StateW'(longint'(lo) + longint'(offset));
  endfunction

  // Pick one bound: any pattern, near zero, or near either end of the range.
  function automatic logic signed [StateW-1:0] pick_bound();
    case ($urandom_range(3))
      0: return StateW'($urandom);
      1: return StateW'(int'($urandom_range(127)) - 64);
      2: return $urandom_range(1) ? MinBound + StateW'($urandom_range(15))
                                  : MaxBound - StateW'($urandom_range(15));
      default: return StateW'($urandom);
    endcase
  endfunction

  // Offer one request beat after a random idle stretch, hold it until it is
  // taken, then queue its expected value. Leave valid high on return.
  task automatic offer_request(input logic signed [StateW-1:0] a,
                               input logic signed [StateW-1:0] b,
                               input logic fixed, input logic signed [StateW-1:0] fixed_val);
    logic signed [StateW-1:0] want;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.bound_a <= a;
    req_ch.bound_b <= b;
    do @(posedge clk_i); while (!req_ch.ready);
    want = draw_in_range(a, b);
    if (fixed) want = fixed_val;
    pending_draws.push_back(want);
  endtask

  // APB transfers: setup cycle, then access until pready. Each task leaves
  // psel low, so leave a clock between back-to-back transfers.
  task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [1:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the seed, mirror it and read it back.
  task automatic program_seed(input logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk_i);
    apb_write(SeedAddr, value);
    seed_copy = value[StateW-1:0];
    @(posedge clk_i);
    apb_read(SeedAddr, readback);
    if (readback[StateW-1:0] !== value[StateW-1:0])
      report_mismatch("seed_value read-back", {1'b0, readback[StateW-1:0]},
                      {1'b0, value[StateW-1:0]});
  endtask

  // Drop valid and hold until every queued draw has come back.
  task automatic wait_for_idle();
    req_ch.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk_i);
  endtask

  // Result side: stall at random, and once hold off for a long stretch so the
  // core fills up and backs up its request channel.
  initial begin : result_sink
    int  hold_left;
    bit  pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!pressure_done && results_seen == PressureAt) begin
        hold_left     = HoldCycles;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result beat with the oldest queued draw.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      results_seen <= results_seen + 1;
      if (pending_draws.size() == 0) begin
        report_mismatch("result beat with no draw pending", {1'b0, rsp_ch.random_value},
                        32'h0);
      end else begin
        logic signed [StateW-1:0] want;
        want = pending_draws.pop_front();
        if (rsp_ch.random_value !== want)
          report_mismatch("random_value", {1'b0, rsp_ch.random_value}, {1'b0, want});
      end
    end
  end

  initial begin : stimulus
    logic signed [StateW-1:0] a;
    logic signed [StateW-1:0] b;

    // Drive every input known from time zero; hold reset low, then release it.
    rst_ni         <= 1'b0;
    req_ch.valid   <= 1'b0;
    req_ch.bound_a <= '0;
    req_ch.bound_b <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The state is zero until the first request, so a zero seed must load 1.
    program_seed(32'h0);

    for (int i = 0; i < NumProbes; i++)
      offer_request(Probes[i].a, Probes[i].b, Probes[i].fixed, Probes[i].want);

    // Random phases. The seed no longer reaches the state once it is running,
    // but write a random value and an extreme each time and read both back.
    for (int phase = 0; phase < 3; phase++) begin
      wait_for_idle();
      program_seed({1'b0, 31'($urandom)});
      program_seed(PhaseSeed[phase]);
      send_idle_pct  = SendIdle[phase];
      recv_stall_pct = RecvStall[phase];
      repeat (RandomPerPhase) begin
        a = pick_bound();
        case ($urandom_range(7))
          0:       b = a;                                     // equal bounds
          1:       b = a + StateW'($urandom_range(1, 40));    // narrow span
          default: b = pick_bound();
        endcase
        offer_request(a, b, 1'b0, '0);
      end
    end

    wait_for_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutCycles * 10);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
